/* rtl/core/owme_pkg.sv */
// Shared types of the single-wire bus master byte engine
package owme_pkg;

  // command codes carried in each tick
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // timing register indexes on the write port
  typedef enum logic [3:0] {
    REG_RESET_LOW  = 4'd0,
    REG_PRES_TAIL  = 4'd1,
    REG_WO_LOW     = 4'd2,
    REG_WO_HIGH    = 4'd3,
    REG_WZ_LOW     = 4'd4,
    REG_WZ_HIGH    = 4'd5,
    REG_READ_LOW   = 4'd6,
    REG_READ_TAIL  = 4'd7
  } reg_idx_e;

  // timing registers, all in microseconds
  typedef struct packed {
    logic [9:0] read_tail;
    logic [9:0] read_low;
    logic [9:0] wz_high;
    logic [9:0] wz_low;
    logic [9:0] wo_high;
    logic [9:0] wo_low;
    logic [9:0] pres_tail;
    logic [9:0] reset_low;
  } cfg_t;

  // one tick request
  typedef struct packed {
    logic       line_level;
    logic [7:0] write_byte;
    cmd_e       command;
  } in_item_t;

  // one tick result
  typedef struct packed {
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       pull_low;
  } out_item_t;

endpackage

/* rtl/core/owme_cfg_regs.sv */
// Timing register file of the single-wire bus master byte engine
module owme_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_idx_i,
  input  logic [9:0]           cfg_wdata_i,
  output owme_pkg::cfg_t       cfg_o
);

  owme_pkg::cfg_t cfg_q;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low <= 10'd500;
      cfg_q.pres_tail <= 10'd50;
      cfg_q.wo_low    <= 10'd1;
      cfg_q.wo_high   <= 10'd60;
      cfg_q.wz_low    <= 10'd60;
      cfg_q.wz_high   <= 10'd5;
      cfg_q.read_low  <= 10'd2;
      cfg_q.read_tail <= 10'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        owme_pkg::REG_RESET_LOW: cfg_q.reset_low <= cfg_wdata_i;
        owme_pkg::REG_PRES_TAIL: cfg_q.pres_tail <= cfg_wdata_i;
        owme_pkg::REG_WO_LOW:    cfg_q.wo_low    <= cfg_wdata_i;
        owme_pkg::REG_WO_HIGH:   cfg_q.wo_high   <= cfg_wdata_i;
        owme_pkg::REG_WZ_LOW:    cfg_q.wz_low    <= cfg_wdata_i;
        owme_pkg::REG_WZ_HIGH:   cfg_q.wz_high   <= cfg_wdata_i;
        owme_pkg::REG_READ_LOW:  cfg_q.read_low  <= cfg_wdata_i;
        owme_pkg::REG_READ_TAIL: cfg_q.read_tail <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/owme_engine.sv */
// Bus sequencer state and its one-tick next-state logic
module owme_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  owme_pkg::in_item_t   item_i,
  input  owme_pkg::cfg_t       cfg_i,
  output owme_pkg::out_item_t  result_o
);

  localparam logic [9:0] ResetHighUs = 10'd20;

  typedef enum logic [11:0] {
    PH_IDLE      = 12'h001,
    PH_RST_HIGH  = 12'h002,
    PH_RST_LOW   = 12'h004,
    PH_WAIT_LOW  = 12'h008,
    PH_WAIT_HIGH = 12'h010,
    PH_PRES_TAIL = 12'h020,
    PH_WR_LOW    = 12'h040,
    PH_WR_HIGH   = 12'h080,
    PH_RD_LOW    = 12'h100,
    PH_RD_GAP    = 12'h200,
    PH_RD_SAMPLE = 12'h400,
    PH_RD_TAIL   = 12'h800
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [9:0] cnt;
    logic [2:0] idx;
    logic [7:0] sh;
    logic       done;
  } step_t;

  phase_e     phase_q;
  logic [9:0] cnt_q;
  logic [2:0] idx_q;
  logic [7:0] sh_q;
  logic [7:0] rx_q, rx_d;
  step_t      st;
  logic       pull;
  logic       busy;

  // start a write slot at bit idx, skipping bits whose slot has no length
  function automatic step_t wr_enter(owme_pkg::cfg_t c, logic [7:0] sh, logic [2:0] idx);
    step_t      r;
    logic       found;
    logic       b;
    logic       nz;
    logic       one_nz;
    logic       zero_nz;
    logic [9:0] lo;
    logic [9:0] hi;
    one_nz  = (c.wo_low != 10'd0) || (c.wo_high != 10'd0);
    zero_nz = (c.wz_low != 10'd0) || (c.wz_high != 10'd0);
    r.phase = PH_IDLE;
    r.cnt   = 10'd0;
    r.idx   = idx;
    r.sh    = sh;
    r.done  = 1'b1;
    found   = 1'b0;
    lo      = 10'd0;
    hi      = 10'd0;
    for (int k = 0; k < 8; k++) begin
      b  = sh[k];
      nz = b ? one_nz : zero_nz;
      if (!found && nz && (({1'b0, idx} + 4'(k)) <= 4'd7)) begin
        found  = 1'b1;
        r.sh   = sh >> k;
        r.idx  = idx + 3'(k);
        r.done = 1'b0;
        lo     = b ? c.wo_low : c.wz_low;
        hi     = b ? c.wo_high : c.wz_high;
        if (lo != 10'd0) begin
          r.phase = PH_WR_LOW;
          r.cnt   = lo;
        end else begin
          r.phase = PH_WR_HIGH;
          r.cnt   = hi;
        end
      end
    end
    return r;
  endfunction

  // start a read slot; the gap always has length so no further skipping
  function automatic step_t rd_enter(owme_pkg::cfg_t c, logic [7:0] sh, logic [2:0] idx);
    step_t r;
    r.idx  = idx;
    r.sh   = sh;
    r.done = 1'b0;
    if (c.read_low != 10'd0) begin
      r.phase = PH_RD_LOW;
      r.cnt   = c.read_low;
    end else begin
      r.phase = PH_RD_GAP;
      r.cnt   = 10'd1;
    end
    return r;
  endfunction

  // one tick: command start, then one tick of the current part
  always_comb begin
    st.phase = phase_q;
    st.cnt   = cnt_q;
    st.idx   = idx_q;
    st.sh    = sh_q;
    st.done  = 1'b0;
    rx_d     = rx_q;
    pull     = 1'b0;
    busy     = 1'b0;

    // command start while idle
    if (phase_q == PH_IDLE && item_i.command != owme_pkg::CMD_NONE) begin
      busy = 1'b1;
      unique case (item_i.command)
        owme_pkg::CMD_RESET: begin
          st.phase = PH_RST_HIGH;
          st.cnt   = ResetHighUs;
          st.idx   = 3'd0;
        end
        owme_pkg::CMD_WRITE: st = wr_enter(cfg_i, item_i.write_byte, 3'd0);
        owme_pkg::CMD_READ:  st = rd_enter(cfg_i, 8'd0, 3'd0);
        default: begin
        end
      endcase
    end

    // tick of the part under way
    if (st.phase != PH_IDLE) begin
      busy = 1'b1;
      pull = (st.phase == PH_RST_LOW) || (st.phase == PH_WR_LOW) || (st.phase == PH_RD_LOW);
      unique case (st.phase)
        PH_WAIT_LOW: begin
          if (!item_i.line_level) st.phase = PH_WAIT_HIGH;
        end
        PH_WAIT_HIGH: begin
          if (item_i.line_level) begin
            if (cfg_i.pres_tail != 10'd0) begin
              st.phase = PH_PRES_TAIL;
              st.cnt   = cfg_i.pres_tail;
            end else begin
              st.phase = PH_IDLE;
              st.cnt   = 10'd0;
              st.done  = 1'b1;
            end
          end
        end
        default: begin
          if (st.phase == PH_RD_SAMPLE) st.sh = {item_i.line_level, st.sh[7:1]};
          if (st.cnt != 10'd0) st.cnt = st.cnt - 10'd1;
          if (st.cnt == 10'd0) begin
            unique case (st.phase)
              PH_RST_HIGH: begin
                if (cfg_i.reset_low != 10'd0) begin
                  st.phase = PH_RST_LOW;
                  st.cnt   = cfg_i.reset_low;
                end else begin
                  st.phase = PH_WAIT_LOW;
                end
              end
              PH_RST_LOW: st.phase = PH_WAIT_LOW;
              PH_PRES_TAIL: begin
                st.phase = PH_IDLE;
                st.done  = 1'b1;
              end
              PH_WR_LOW: begin
                if ((st.sh[0] ? cfg_i.wo_high : cfg_i.wz_high) != 10'd0) begin
                  st.phase = PH_WR_HIGH;
                  st.cnt   = st.sh[0] ? cfg_i.wo_high : cfg_i.wz_high;
                end else if (st.idx == 3'd7) begin
                  st.phase = PH_IDLE;
                  st.done  = 1'b1;
                end else begin
                  st = wr_enter(cfg_i, {1'b0, st.sh[7:1]}, st.idx + 3'd1);
                end
              end
              PH_WR_HIGH: begin
                if (st.idx == 3'd7) begin
                  st.phase = PH_IDLE;
                  st.done  = 1'b1;
                end else begin
                  st = wr_enter(cfg_i, {1'b0, st.sh[7:1]}, st.idx + 3'd1);
                end
              end
              PH_RD_LOW: begin
                st.phase = PH_RD_GAP;
                st.cnt   = 10'd1;
              end
              PH_RD_GAP: begin
                st.phase = PH_RD_SAMPLE;
                st.cnt   = 10'd1;
              end
              PH_RD_SAMPLE: begin
                if (cfg_i.read_tail > 10'd1) begin
                  st.phase = PH_RD_TAIL;
                  st.cnt   = cfg_i.read_tail - 10'd1;
                end else if (st.idx == 3'd7) begin
                  rx_d     = st.sh;
                  st.phase = PH_IDLE;
                  st.done  = 1'b1;
                end else begin
                  st = rd_enter(cfg_i, st.sh, st.idx + 3'd1);
                end
              end
              PH_RD_TAIL: begin
                if (st.idx == 3'd7) begin
                  rx_d     = st.sh;
                  st.phase = PH_IDLE;
                  st.done  = 1'b1;
                end else begin
                  st = rd_enter(cfg_i, st.sh, st.idx + 3'd1);
                end
              end
              default: begin
                st.phase = PH_IDLE;
                st.done  = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  // sequencer state, moves once per tick taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= 10'd0;
      idx_q   <= 3'd0;
      sh_q    <= 8'd0;
      rx_q    <= 8'd0;
    end else if (advance_i) begin
      phase_q <= st.phase;
      cnt_q   <= st.cnt;
      idx_q   <= st.idx;
      sh_q    <= st.sh;
      rx_q    <= rx_d;
    end
  end

  assign result_o.pull_low  = pull;
  assign result_o.busy_res  = busy;
  assign result_o.done_res  = st.done;
  assign result_o.read_byte = rx_d;

endmodule

/* rtl/core/one_wire_master_byte_engine_unit.sv */
// Single-wire bus master byte engine, top level with stream ports
//
// Each request on the slave stream is one microsecond tick carrying the sampled
// bus level and, while the engine is idle, a command (reset and presence, write a
// byte least significant bit first, or read a byte); each tick yields exactly one
// result with the pull-low drive, busy and done flags and the last byte read.
// One tick is taken every clock cycle while the result side keeps up: a tick
// passes an input register, the combinational sequencer step and a result
// register, and backpressure on the master side holds both registers. Timing
// registers are written through the plain write port and take effect on the
// next part of a command that starts; the presence wait has no timeout, so a
// missing device keeps the engine busy until reset.
module one_wire_master_byte_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // timing register write port
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  // tick requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // command[1:0], write_byte[9:2], line_level[10]
  // tick results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // pull_low[0], busy_res[1], done_res[2], read_byte[10:3]
);

  owme_pkg::cfg_t      cfg;
  owme_pkg::in_item_t  in_item_q;
  owme_pkg::out_item_t result;
  owme_pkg::out_item_t out_item_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_take;

  owme_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // a tick moves from input to result register when the result slot frees
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.command    <= owme_pkg::cmd_e'(s_axis_tdata_i[1:0]);
      in_item_q.write_byte <= s_axis_tdata_i[9:2];
      in_item_q.line_level <= s_axis_tdata_i[10];
    end
  end

  owme_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_item_q.read_byte, out_item_q.done_res,
                            out_item_q.busy_res, out_item_q.pull_low};

endmodule

/* verif/one_wire_master_byte_engine_unit_tb.sv */
// Self-checking stream testbench for the single-wire bus master byte engine
`timescale 1ns / 1ps

module one_wire_master_byte_engine_unit_tb;

  // sequencer parts mirrored by the tick predictor
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_HIGH,
    PH_RST_LOW,
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_PRES_TAIL,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_RD_LOW,
    PH_RD_GAP,
    PH_RD_SAMPLE,
    PH_RD_TAIL,
    PH_DONE
  } seq_phase_e;

  // range of register indexes that hit no register
  localparam int REG_COUNT      = 8;
  localparam int REG_IDX_MAX    = 15;

  localparam logic [9:0] RESET_HIGH_TICKS = 10'd20;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_TICKS      = 30;
  localparam int CALM_PHASES      = 2;
  localparam int DRAIN_CYCLES     = 8;
  localparam int TIMEOUT_NS       = 100_000_000;

  localparam owme_pkg::cfg_t CFG_DEFAULT = '{read_tail: 10'd10, read_low: 10'd2,
                                             wz_high: 10'd5, wz_low: 10'd60,
                                             wo_high: 10'd60, wo_low: 10'd1,
                                             pres_tail: 10'd50, reset_low: 10'd500};

  // directed stimulus row: tick, optional hand-written result, zero timing before it
  typedef struct packed {
    owme_pkg::in_item_t  stim;
    logic                typed;
    owme_pkg::out_item_t want;
    logic                zero_cfg;
  } dir_row_t;

  localparam owme_pkg::out_item_t QUIET_TICK   = '0;
  localparam owme_pkg::out_item_t INSTANT_DONE = '{read_byte: 8'h00, done_res: 1'b1,
                                                   busy_res: 1'b1, pull_low: 1'b0};
  localparam int DIR_ROWS = 22;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // idle with no command, extremes of the data field
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b1, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'hFF, owme_pkg::CMD_NONE},  1'b1, QUIET_TICK,   1'b0},
    // all timing zero: writes finish on the accepting tick
    '{'{1'b1, 8'hFF, owme_pkg::CMD_WRITE}, 1'b1, INSTANT_DONE, 1'b1},
    '{'{1'b0, 8'h00, owme_pkg::CMD_WRITE}, 1'b1, INSTANT_DONE, 1'b0},
    // read at zero timing, sample and gap ticks alternate
    '{'{1'b0, 8'h5A, owme_pkg::CMD_READ},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    // command while busy is dropped
    '{'{1'b1, 8'hFF, owme_pkg::CMD_WRITE}, 1'b0, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h81, owme_pkg::CMD_RESET}, 1'b0, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b1, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    // byte just read shows up, then a reset sequence starts
    '{'{1'b1, 8'hFF, owme_pkg::CMD_NONE},  1'b0, QUIET_TICK,   1'b0},
    '{'{1'b0, 8'h00, owme_pkg::CMD_RESET}, 1'b0, QUIET_TICK,   1'b0}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [3:0]  cfg_idx_i       = '0;
  logic [9:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;  // command[1:0], write_byte[9:2], line_level[10]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // pull_low[0], busy_res[1], done_res[2], read_byte[10:3]

  // predictor state
  seq_phase_e     seq_ph    = PH_IDLE;
  logic [9:0]     seq_cnt   = '0;
  logic [2:0]     seq_bit   = '0;
  logic [7:0]     seq_shift = '0;
  logic [7:0]     seq_rx    = '0;
  owme_pkg::cfg_t seq_cfg   = CFG_DEFAULT;

  owme_pkg::out_item_t expected_ticks [$];
  int                  ticks_sent = 0;
  int                  fail_count = 0;

  // idling control shared by both sides
  int                  idle_odds  = 4;
  logic                calm       = 1'b0;
  logic                hold_armed = 1'b0;
  logic                hold_done  = 1'b0;
  int                  hold_left  = 0;
  int                  rx_gap     = 0;
  owme_pkg::out_item_t got_tick;
  owme_pkg::out_item_t want_tick;

  one_wire_master_byte_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // part that follows p, stepping the bit counters at slot ends
  function automatic seq_phase_e next_part(input seq_phase_e p);
    seq_phase_e nxt;
    case (p)
      PH_RST_HIGH:  nxt = PH_RST_LOW;
      PH_RST_LOW:   nxt = PH_WAIT_LOW;
      PH_WAIT_LOW:  nxt = PH_WAIT_HIGH;
      PH_WAIT_HIGH: nxt = PH_PRES_TAIL;
      PH_WR_LOW:    nxt = PH_WR_HIGH;
      PH_WR_HIGH: begin
        seq_shift = seq_shift >> 1;
        if (seq_bit == 3'd7) begin
          nxt = PH_DONE;
        end else begin
          seq_bit = seq_bit + 3'd1;
          nxt = PH_WR_LOW;
        end
      end
      PH_RD_LOW:    nxt = PH_RD_GAP;
      PH_RD_GAP:    nxt = PH_RD_SAMPLE;
      PH_RD_SAMPLE: nxt = PH_RD_TAIL;
      PH_RD_TAIL: begin
        if (seq_bit == 3'd7) begin
          seq_rx = seq_shift;
          nxt = PH_DONE;
        end else begin
          seq_bit = seq_bit + 3'd1;
          nxt = PH_RD_LOW;
        end
      end
      default:      nxt = PH_DONE;
    endcase
    return nxt;
  endfunction

  // move into part p, skipping zero-length parts; returns 1 when the command ends
  function automatic logic enter_part(input seq_phase_e p);
    logic [9:0] len;
    logic       fin;
    logic       settled;
    fin     = 1'b0;
    settled = 1'b0;
    while (!settled) begin
      if (p == PH_DONE) begin
        seq_ph  = PH_IDLE;
        seq_cnt = '0;
        fin     = 1'b1;
        settled = 1'b1;
      end else if (p == PH_WAIT_LOW || p == PH_WAIT_HIGH) begin
        seq_ph  = p;
        seq_cnt = '0;
        settled = 1'b1;
      end else begin
        case (p)
          PH_RST_HIGH:  len = RESET_HIGH_TICKS;
          PH_RST_LOW:   len = seq_cfg.reset_low;
          PH_PRES_TAIL: len = seq_cfg.pres_tail;
          PH_WR_LOW:    len = seq_shift[0] ? seq_cfg.wo_low : seq_cfg.wz_low;
          PH_WR_HIGH:   len = seq_shift[0] ? seq_cfg.wo_high : seq_cfg.wz_high;
          PH_RD_LOW:    len = seq_cfg.read_low;
          PH_RD_GAP,
          PH_RD_SAMPLE: len = 10'd1;
          PH_RD_TAIL:   len = (seq_cfg.read_tail != '0) ? seq_cfg.read_tail - 10'd1 : '0;
          default:      len = '0;
        endcase
        if (len != '0) begin
          seq_ph  = p;
          seq_cnt = len;
          settled = 1'b1;
        end else begin
          p = next_part(p);
        end
      end
    end
    return fin;
  endfunction

  // one microsecond tick through the predictor
  function automatic owme_pkg::out_item_t engine_tick(input owme_pkg::in_item_t it);
    owme_pkg::out_item_t r;
    r = '0;
    if (seq_ph == PH_IDLE && it.command != owme_pkg::CMD_NONE) begin
      seq_bit    = '0;
      r.busy_res = 1'b1;
      case (it.command)
        owme_pkg::CMD_RESET: r.done_res = enter_part(PH_RST_HIGH);
        owme_pkg::CMD_WRITE: begin
          seq_shift  = it.write_byte;
          r.done_res = enter_part(PH_WR_LOW);
        end
        default: begin
          seq_shift  = '0;
          r.done_res = enter_part(PH_RD_LOW);
        end
      endcase
    end
    if (seq_ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      r.pull_low = (seq_ph == PH_RST_LOW || seq_ph == PH_WR_LOW || seq_ph == PH_RD_LOW);
      if (seq_ph == PH_WAIT_LOW) begin
        if (!it.line_level) seq_ph = PH_WAIT_HIGH;
      end else if (seq_ph == PH_WAIT_HIGH) begin
        if (it.line_level) r.done_res = enter_part(PH_PRES_TAIL);
      end else begin
        if (seq_ph == PH_RD_SAMPLE) seq_shift = {it.line_level, seq_shift[7:1]};
        if (seq_cnt != '0) seq_cnt = seq_cnt - 10'd1;
        if (seq_cnt == '0) r.done_res = enter_part(next_part(seq_ph));
      end
    end
    r.read_byte = seq_rx;
    return r;
  endfunction

  // next tick: device-like line behavior in the wait parts, noise elsewhere
  function automatic owme_pkg::in_item_t make_tick(input logic want_cmd);
    owme_pkg::in_item_t it;
    it.write_byte = 8'($urandom);
    it.line_level = 1'($urandom);
    if (seq_ph == PH_WAIT_LOW) it.line_level = ($urandom_range(0, 3) != 0);
    if (seq_ph == PH_WAIT_HIGH) it.line_level = ($urandom_range(0, 3) != 0);
    if (seq_ph == PH_IDLE) begin
      if (want_cmd && $urandom_range(0, 3) != 0)
        it.command = owme_pkg::cmd_e'($urandom_range(owme_pkg::CMD_RESET,
                                                     owme_pkg::CMD_READ));
      else
        it.command = owme_pkg::CMD_NONE;
    end else begin
      it.command = ($urandom_range(0, 7) == 0)
                   ? owme_pkg::cmd_e'($urandom_range(owme_pkg::CMD_NONE, owme_pkg::CMD_READ))
                   : owme_pkg::CMD_NONE;
    end
    return it;
  endfunction

  // offer one tick request, predict it once taken
  task automatic send_tick(input owme_pkg::in_item_t it, input logic typed,
                           input owme_pkg::out_item_t want);
    int                  gap;
    owme_pkg::out_item_t r;
    if (idle_odds != 0 && hold_left == 0 && !calm && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, it};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = engine_tick(it);
    ticks_sent++;
    expected_ticks.push_back(typed ? want : r);
  endtask

  // feed plain ticks until the predicted sequencer is idle
  task automatic drain_to_idle();
    while (seq_ph != PH_IDLE) send_tick(make_tick(1'b0), 1'b0, QUIET_TICK);
  endtask

  // let every expected result come out before touching registers
  task automatic settle();
    drain_to_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all timing registers, then one unmapped index
  task automatic load_timing(input owme_pkg::cfg_t c);
    logic [$bits(owme_pkg::cfg_t)-1:0] flat;
    flat = c;
    for (int i = int'(owme_pkg::REG_RESET_LOW); i <= int'(owme_pkg::REG_READ_TAIL); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 4'(i);
      cfg_wdata_i <= flat[i*10 +: 10];
      @(posedge clk_i);
    end
    cfg_idx_i   <= 4'($urandom_range(REG_COUNT, REG_IDX_MAX));
    cfg_wdata_i <= 10'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seq_cfg = c;
  endtask

  // one command of a given kind, run to completion
  task automatic run_one(input owme_pkg::cmd_e c);
    owme_pkg::in_item_t it;
    it = make_tick(1'b1);
    it.command = c;
    send_tick(it, 1'b0, QUIET_TICK);
    drain_to_idle();
  endtask

  // result side: check against the oldest expectation, idle and hold off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_tick = owme_pkg::out_item_t'(m_axis_tdata_o[10:0]);
        if (expected_ticks.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result %03h with nothing pending", m_axis_tdata_o[10:0]);
          fail_count++;
        end else begin
          want_tick = expected_ticks.pop_front();
          if (got_tick.pull_low !== want_tick.pull_low ||
              got_tick.busy_res !== want_tick.busy_res ||
              got_tick.done_res !== want_tick.done_res ||
              got_tick.read_byte !== want_tick.read_byte) begin
            if (fail_count < 10)
              $display("mismatch exp/act: pull %b/%b busy %b/%b done %b/%b byte %02h/%02h",
                       want_tick.pull_low, got_tick.pull_low,
                       want_tick.busy_res, got_tick.busy_res,
                       want_tick.done_res, got_tick.done_res,
                       want_tick.read_byte, got_tick.read_byte);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (hold_armed && !hold_done) begin
        hold_left       <= HOLD_CYCLES;
        hold_done       <= 1'b1;
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap          <= rx_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        rx_gap          <= $urandom_range(0, 9);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [$bits(owme_pkg::cfg_t)-1:0] flat;
    int                                phase_base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (DIR_TABLE[row].zero_cfg) begin
        settle();
        load_timing(owme_pkg::cfg_t'('0));
      end
      send_tick(DIR_TABLE[row].stim, DIR_TABLE[row].typed, DIR_TABLE[row].want);
    end

    // a read at the usual timing
    settle();
    load_timing(CFG_DEFAULT);
    run_one(owme_pkg::CMD_READ);

    // random commands over many short timing settings, no idling at the end
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      for (int i = int'(owme_pkg::REG_RESET_LOW); i <= int'(owme_pkg::REG_READ_TAIL); i++)
        flat[i*10 +: 10] = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 30))
                                                        : 10'($urandom_range(0, 4));
      load_timing(owme_pkg::cfg_t'(flat));
      case ($urandom_range(0, 2))
        0:       idle_odds <= 0;
        1:       idle_odds <= 3;
        default: idle_odds <= 12;
      endcase
      if (p == 1) hold_armed <= 1'b1;
      if (p >= RANDOM_PHASES - CALM_PHASES) calm <= 1'b1;
      phase_base = ticks_sent;
      while (ticks_sent - phase_base < PHASE_TICKS)
        send_tick(make_tick(1'b1), 1'b0, QUIET_TICK);
    end

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
